// ----- design/bgs_pkg.sv -----
package bgs_pkg;

    localparam int SITES   = 64;
    localparam int SITE_W  = $clog2(SITES);
    localparam int WADDR_W = 2 * SITE_W;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 24;
    localparam int PROB_W  = 16;
    localparam int LOGI_LAST = 32;

    localparam logic [2:0] FN_BIAS   = 3'd0;
    localparam logic [2:0] FN_WEIGHT = 3'd1;
    localparam logic [2:0] FN_SET    = 3'd2;
    localparam logic [2:0] FN_ASYNC  = 3'd3;
    localparam logic [2:0] FN_SYNC   = 3'd4;
    localparam logic [2:0] FN_COMMIT = 3'd5;

    // round(65536 / (1 + exp(-k/4)))
    localparam logic [PROB_W-1:0] LOGI_TAB [0:LOGI_LAST] = '{
        16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941,
        16'd53581, 16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61598,
        16'd62428, 16'd63090, 16'd63615, 16'd64030, 16'd64357, 16'd64614,
        16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328,
        16'd65374, 16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489,
        16'd65500, 16'd65508, 16'd65514
    };

    typedef struct packed {
        logic en;     // accumulate this cycle
        logic first;  // start from the bias
        logic skip;   // diagonal term
        logic sub;    // neighbor bit is one
    } acc_ctrl_t;

    // clip a 26-bit signed value to the 24-bit accumulator range
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W+1:0] v);
        logic ovf;
        ovf = (v[ACC_W+1:ACC_W-1] != 3'b000) && (v[ACC_W+1:ACC_W-1] != 3'b111);
        if (!ovf)
            return v[ACC_W-1:0];
        else if (v[ACC_W+1])
            return {1'b1, {(ACC_W-1){1'b0}}};
        else
            return {1'b0, {(ACC_W-1){1'b1}}};
    endfunction

    function automatic logic [PROB_W-1:0] logistic(input logic signed [ACC_W-1:0] d);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-11:0] k;
        logic [5:0] idx;
        logic [PROB_W:0] p;
        mag = d[ACC_W-1] ? ACC_W'(-d) : ACC_W'(d);
        k   = mag[ACC_W-1:10];
        idx = (k > (ACC_W-10)'(LOGI_LAST)) ? 6'(LOGI_LAST) : k[5:0];
        if (d[ACC_W-1])
            p = 17'h10000 - {1'b0, LOGI_TAB[idx]};
        else
            p = {1'b0, LOGI_TAB[idx]};
        return p[PROB_W-1:0];
    endfunction

endpackage

// ----- design/boltzmann_gibbs_sampler.sv -----
// Loads, set bit, commit and unknown codes: result registered, valid in the cycle after accept.
// Update and sync step: result after the FETCH, ACC, DELTA and DONE states; one
// weight read and one saturating add per cycle through the single weight port.
// One load per cycle while each result is taken; no request is accepted while an update runs.
// Reset (rst_n low, async): idle, no result pending, state and shadow bits 0.
// Bias and weight stores are not cleared.
module boltzmann_gibbs_sampler
    import bgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              func,
    input  logic [SITE_W-1:0]       site,
    input  logic [SITE_W-1:0]       column,
    input  logic signed [VAL_W-1:0] value,
    input  logic [PROB_W-1:0]       uniform,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SITE_W-1:0]       site_out,
    output logic [PROB_W-1:0]       probability,
    output logic                    new_bit
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FETCH = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_DELTA = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]              state_reg;
    logic                    first_reg;
    logic                    out_valid_reg;
    logic [SITES-1:0]        spin_reg;
    logic [SITES-1:0]        shadow_reg;
    logic [SITE_W-1:0]       site_reg;
    logic [PROB_W-1:0]       uni_reg;
    logic                    sync_reg;
    logic [SITE_W-1:0]       j_reg;
    logic [SITE_W-1:0]       jd_reg;
    logic signed [ACC_W-1:0] delta_reg;
    logic [SITE_W-1:0]       site_out_reg;
    logic [PROB_W-1:0]       prob_reg;
    logic                    bit_reg;

    logic                    accept;
    logic                    in_range;
    logic                    col_ok;
    logic                    is_update;
    logic [SITE_W-1:0]       imm_site;
    logic                    imm_bit;
    logic [VAL_W-1:0]        bias_q;
    logic [VAL_W-1:0]        weight_q;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W+1:0] acc_x2;
    logic [PROB_W-1:0]       p_done;
    logic                    nb_done;
    acc_ctrl_t               ctrl;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(site) < SITES);
    assign col_ok   = (32'(column) < SITES);

    always_comb
    begin
        is_update = (func inside {FN_ASYNC, FN_SYNC}) && in_range;
        imm_site  = (func inside {FN_BIAS, FN_WEIGHT, FN_SET, FN_ASYNC, FN_SYNC}) ?
                    site : '0;
        imm_bit   = (func == FN_SET) && in_range && value[0];
    end

    bgs_store u_store (
        .clk       (clk),
        .bias_we   (accept && func == FN_BIAS && in_range),
        .weight_we (accept && func == FN_WEIGHT && in_range && col_ok),
        .wr_row    (site),
        .wr_col    (column),
        .wr_data   (value),
        .rd_row    (site_reg),
        .rd_col    (j_reg),
        .bias_q    (bias_q),
        .weight_q  (weight_q)
    );

    always_comb
    begin
        ctrl.en    = (state_reg == ST_ACC);
        ctrl.first = first_reg;
        ctrl.skip  = (jd_reg == site_reg);
        ctrl.sub   = spin_reg[jd_reg];
    end

    bgs_accum u_accum (
        .clk    (clk),
        .ctrl   (ctrl),
        .bias   (bias_q),
        .weight (weight_q),
        .acc    (acc)
    );

    // delta = -2 * acc
    assign acc_x2  = {acc[ACC_W-1], acc, 1'b0};
    assign p_done  = logistic(delta_reg);
    assign nb_done = (uni_reg < p_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            spin_reg      <= '0;
            shadow_reg    <= '0;
        end
        else
        begin
            if ((accept && !is_update) || state_reg == ST_DONE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_update)
                            state_reg <= ST_FETCH;
                        if (func == FN_SET && in_range)
                            spin_reg[site] <= value[0];
                        if (func == FN_COMMIT)
                            spin_reg <= shadow_reg;
                    end
                end
                ST_FETCH:
                begin
                    first_reg <= 1'b1;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    first_reg <= 1'b0;
                    if (32'(jd_reg) == SITES - 1)
                        state_reg <= ST_DELTA;
                end
                ST_DELTA:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (sync_reg)
                        shadow_reg[site_reg] <= nb_done;
                    else
                        spin_reg[site_reg] <= nb_done;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            site_reg <= site;
            uni_reg  <= uniform;
            sync_reg <= (func == FN_SYNC);
            j_reg    <= '0;
            if (!is_update)
            begin
                site_out_reg <= imm_site;
                prob_reg     <= '0;
                bit_reg      <= imm_bit;
            end
        end
        else if (state_reg == ST_FETCH || state_reg == ST_ACC)
        begin
            jd_reg <= j_reg;
            j_reg  <= j_reg + 1'b1;
        end
        if (state_reg == ST_DELTA)
            delta_reg <= sat_acc(-acc_x2);
        if (state_reg == ST_DONE)
        begin
            site_out_reg <= site_reg;
            prob_reg     <= p_done;
            bit_reg      <= nb_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign site_out    = site_out_reg;
    assign probability = prob_reg;
    assign new_bit     = bit_reg;

`ifndef SYNTHESIS
    a_update_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (func == FN_ASYNC || func == FN_SYNC) |=> !out_valid)
        else $error("update result appeared too early");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && probability != 16'd0 |-> probability >= 16'd22 && probability <= 16'd65514)
        else $error("probability outside logistic range");

    a_commit_copy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && func == FN_COMMIT |=> spin_reg == $past(shadow_reg))
        else $error("commit did not copy shadow state");
`endif

endmodule

// ----- design/bgs_store.sv -----
module bgs_store
    import bgs_pkg::*;
(
    input  logic                    clk,
    input  logic                    bias_we,
    input  logic                    weight_we,
    input  logic [SITE_W-1:0]       wr_row,
    input  logic [SITE_W-1:0]       wr_col,
    input  logic [VAL_W-1:0]        wr_data,
    input  logic [SITE_W-1:0]       rd_row,
    input  logic [SITE_W-1:0]       rd_col,
    output logic [VAL_W-1:0]        bias_q,
    output logic [VAL_W-1:0]        weight_q
);

    logic [VAL_W-1:0] bias_mem   [0:SITES-1];
    logic [VAL_W-1:0] weight_mem [0:SITES*SITES-1];

    always_ff @(posedge clk)
    begin
        if (bias_we)
            bias_mem[wr_row] <= wr_data;
        bias_q <= bias_mem[rd_row];
    end

    always_ff @(posedge clk)
    begin
        if (weight_we)
            weight_mem[{wr_row, wr_col}] <= wr_data;
        weight_q <= weight_mem[{rd_row, rd_col}];
    end

endmodule

// ----- design/bgs_accum.sv -----
module bgs_accum
    import bgs_pkg::*;
(
    input  logic                    clk,
    input  acc_ctrl_t               ctrl,
    input  logic signed [VAL_W-1:0] bias,
    input  logic signed [VAL_W-1:0] weight,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] base;
    logic signed [ACC_W+1:0] base_x;
    logic signed [ACC_W+1:0] w_x;

    always_comb
    begin
        base   = ctrl.first ? ACC_W'(bias) : acc_reg;
        base_x = (ACC_W+2)'(base);
        w_x    = (ACC_W+2)'(weight);
        if (ctrl.skip)
            acc_next = base;
        else if (ctrl.sub)
            acc_next = sat_acc(base_x - w_x);
        else
            acc_next = sat_acc(base_x + w_x);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en)
            acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

// ----- bench/boltzmann_gibbs_sampler_tb.sv -----
`timescale 1ns / 100ps

module boltzmann_gibbs_sampler_tb;
    import bgs_pkg::*;

    // codes the block answers with an all-zero result
    localparam logic [2:0] FN_SPARE6 = 3'd6;
    localparam logic [2:0] FN_SPARE7 = 3'd7;

    localparam int ACC_TOP         = 2 ** (ACC_W - 1) - 1;
    localparam int ACC_BOTTOM      = -(2 ** (ACC_W - 1));
    localparam int CYCLE_LIMIT     = 500_000;
    localparam int RANDOM_REQUESTS = 750;

    typedef struct packed {
        logic [SITE_W-1:0] site;
        logic [PROB_W-1:0] prob;
        logic              spin;
    } site_result_t;

    class gibbs_scoreboard;
        logic signed [VAL_W-1:0] bias_q [SITES];
        logic signed [VAL_W-1:0] weight_q [SITES][SITES];
        logic                    spin_q [SITES];
        logic                    shadow_q [SITES];
        logic [PROB_W-1:0]       sigmoid_q [0:LOGI_LAST];
        site_result_t            awaited [$];
        int                      errors;

        function new();
            // round(65536 / (1 + exp(-k/4)))
            sigmoid_q = '{
                16'd32768, 16'd36843, 16'd40793, 16'd44511, 16'd47911, 16'd50941,
                16'd53581, 16'd55834, 16'd57724, 16'd59287, 16'd60565, 16'd61598,
                16'd62428, 16'd63090, 16'd63615, 16'd64030, 16'd64357, 16'd64614,
                16'd64816, 16'd64974, 16'd65097, 16'd65194, 16'd65269, 16'd65328,
                16'd65374, 16'd65410, 16'd65438, 16'd65459, 16'd65476, 16'd65489,
                16'd65500, 16'd65508, 16'd65514
            };
            foreach (spin_q[i])
            begin
                spin_q[i]   = 1'b0;
                shadow_q[i] = 1'b0;
            end
            errors = 0;
        endfunction

        static function int clip24(int v);
            if (v > ACC_TOP)
                return ACC_TOP;
            if (v < ACC_BOTTOM)
                return ACC_BOTTOM;
            return v;
        endfunction

        // Q0.16 chance that site s flips to one, given the current live state
        function logic [PROB_W-1:0] site_chance(logic [SITE_W-1:0] s);
            int acc;
            int delta;
            int mag;
            int k;
            acc = bias_q[s];
            for (int j = 0; j < SITES; j++)
            begin
                if (j != s)
                    acc = clip24(spin_q[j] ? acc - weight_q[s][j] : acc + weight_q[s][j]);
            end
            delta = clip24(-2 * acc);
            mag   = (delta < 0) ? -delta : delta;
            k     = mag >> 10;
            if (k > LOGI_LAST)
                k = LOGI_LAST;
            if (delta < 0)
                return PROB_W'(65536 - sigmoid_q[k]);
            return sigmoid_q[k];
        endfunction

        function void note_request(logic [2:0] fn, logic [SITE_W-1:0] s,
                                   logic [SITE_W-1:0] col, logic signed [VAL_W-1:0] val,
                                   logic [PROB_W-1:0] uni);
            site_result_t r;
            r.site = s;
            r.prob = '0;
            r.spin = 1'b0;
            case (fn)
                FN_BIAS:   bias_q[s] = val;
                FN_WEIGHT: weight_q[s][col] = val;
                FN_SET:
                begin
                    r.spin    = val[0];
                    spin_q[s] = val[0];
                end
                FN_ASYNC, FN_SYNC:
                begin
                    r.prob = site_chance(s);
                    r.spin = (uni < r.prob);
                    if (fn == FN_ASYNC)
                        spin_q[s] = r.spin;
                    else
                        shadow_q[s] = r.spin;
                end
                FN_COMMIT:
                begin
                    spin_q = shadow_q;
                    r.site = '0;
                end
                default:   r.site = '0;
            endcase
            awaited.push_back(r);
        endfunction

        function void check_result(logic [SITE_W-1:0] s, logic [PROB_W-1:0] p, logic b);
            site_result_t e;
            if (awaited.size() == 0)
            begin
                $error("unexpected result: site_out %0d probability %0d new_bit %0d", s, p, b);
                errors++;
                return;
            end
            e = awaited.pop_front();
            if (s !== e.site)
            begin
                $error("site_out: expected %0d, got %0d", e.site, s);
                errors++;
            end
            if (p !== e.prob)
            begin
                $error("probability: expected %0d, got %0d", e.prob, p);
                errors++;
            end
            if (b !== e.spin)
            begin
                $error("new_bit: expected %0d, got %0d", e.spin, b);
                errors++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [2:0]              func = FN_BIAS;
    logic [SITE_W-1:0]       site = '0;
    logic [SITE_W-1:0]       column = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic [PROB_W-1:0]       uniform = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [SITE_W-1:0]       site_out;
    logic [PROB_W-1:0]       probability;
    logic                    new_bit;

    gibbs_scoreboard sb = new();
    bit steady_tx = 1'b1;
    bit steady_rx = 1'b1;
    int rx_hold = 0;
    int cycles = 0;

    boltzmann_gibbs_sampler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .site        (site),
        .column      (column),
        .value       (value),
        .uniform     (uniform),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .site_out    (site_out),
        .probability (probability),
        .new_bit     (new_bit)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[boltzmann_gibbs_sampler] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(site_out, probability, new_bit);
    end

    // result side: random stall before each result unless steady_rx is set, plus one long hold on request
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            else
                gap = steady_rx ? 0 : $urandom_range(0, 17);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // called at a clock edge; in_valid stays high on return, callers that
    // wait afterwards must lower it first
    task automatic issue_request(input logic [2:0] fn, input logic [SITE_W-1:0] s,
                                 input logic [SITE_W-1:0] col,
                                 input logic signed [VAL_W-1:0] val,
                                 input logic [PROB_W-1:0] uni);
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        func     <= fn;
        site     <= s;
        column   <= col;
        value    <= val;
        uniform  <= uni;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sb.note_request(fn, s, col, val, uni);
    endtask

    task automatic settle_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return VAL_W'($urandom_range(0, 1023) - 512);
            6, 7:             return VAL_W'($urandom);
            8:                return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default:          return $urandom_range(0, 1) ? 16'sh0001 : 16'shFFFF;
        endcase
    endfunction

    function automatic logic [SITE_W-1:0] pick_site();
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(0, 1) ? SITE_W'(SITES - 1) : '0;
        return SITE_W'($urandom);
    endfunction

    // lean on the compare boundary: uniform equal to p must give zero
    function automatic logic [PROB_W-1:0] pick_uniform(logic [PROB_W-1:0] p);
        case ($urandom_range(0, 5))
            0:       return p;
            1:       return p - 16'd1;
            2:       return p + 16'd1;
            3:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return PROB_W'($urandom);
        endcase
    endfunction

    task automatic update_request(input logic [2:0] fn);
        logic [SITE_W-1:0] s;
        s = pick_site();
        issue_request(fn, s, SITE_W'($urandom), VAL_W'($urandom),
                      pick_uniform(sb.site_chance(s)));
    endtask

    // sync steps over a few sites, usually closed by a commit
    task automatic sync_sweep();
        int count;
        count = $urandom_range(3, 8);
        repeat (count) update_request(FN_SYNC);
        if ($urandom_range(0, 3) != 0)
            issue_request(FN_COMMIT, SITE_W'($urandom), SITE_W'($urandom),
                          VAL_W'($urandom), PROB_W'($urandom));
    endtask

    task automatic random_request();
        logic [SITE_W-1:0] s;
        logic [SITE_W-1:0] col;
        s   = pick_site();
        col = ($urandom_range(0, 3) == 0) ? s : SITE_W'($urandom);
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5:
                issue_request(FN_WEIGHT, s, col, pick_value(), PROB_W'($urandom));
            6, 7:
                issue_request(FN_BIAS, s, col, pick_value(), PROB_W'($urandom));
            8, 9:
                issue_request(FN_SET, s, col, VAL_W'($urandom), PROB_W'($urandom));
            10, 11, 12, 13, 14:
                update_request(FN_ASYNC);
            15, 16:
                update_request(FN_SYNC);
            17:
                issue_request(FN_COMMIT, s, col, VAL_W'($urandom), PROB_W'($urandom));
            default:
                issue_request($urandom_range(0, 1) ? FN_SPARE6 : FN_SPARE7, s, col,
                              VAL_W'($urandom), PROB_W'($urandom));
        endcase
    endtask

    initial
    begin : stimulus
        logic [PROB_W-1:0] p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // every bias and weight gets written before any update reads it
        for (int i = 0; i < SITES; i++)
            issue_request(FN_BIAS, SITE_W'(i), SITE_W'($urandom),
                          VAL_W'($urandom_range(0, 2047) - 1024), PROB_W'($urandom));
        for (int i = 0; i < SITES; i++)
            for (int j = 0; j < SITES; j++)
                issue_request(FN_WEIGHT, SITE_W'(i), SITE_W'(j),
                              VAL_W'($urandom_range(0, 1023) - 512), PROB_W'($urandom));

        steady_tx = 1'b0;
        steady_rx = 1'b0;
        issue_request(FN_BIAS, 6'd0, 6'd0, 16'sh7FFF, 16'd0);
        issue_request(FN_BIAS, 6'd63, 6'd63, 16'sh8000, 16'hFFFF);
        issue_request(FN_WEIGHT, 6'd0, 6'd63, 16'sh7FFF, 16'd0);
        issue_request(FN_WEIGHT, 6'd63, 6'd0, 16'sh8000, 16'd0);
        issue_request(FN_WEIGHT, 6'd0, 6'd0, 16'shFFFF, 16'd0);   // diagonal, never summed
        issue_request(FN_SET, 6'd1, 6'd0, 16'shFFFF, 16'd0);
        issue_request(FN_SET, 6'd2, 6'd0, 16'shFFFE, 16'd0);
        issue_request(FN_ASYNC, 6'd0, 6'd0, 16'sd0, 16'h0000);
        issue_request(FN_ASYNC, 6'd63, 6'd0, 16'sd0, 16'hFFFF);
        p = sb.site_chance(6'd0);
        issue_request(FN_SYNC, 6'd0, 6'd0, 16'sd0, p);
        p = sb.site_chance(6'd63);
        issue_request(FN_SYNC, 6'd63, 6'd0, 16'sd0, p - 16'd1);
        issue_request(FN_COMMIT, 6'd17, 6'd3, 16'sd0, 16'd0);
        issue_request(FN_SPARE6, 6'd5, 6'd9, 16'sh1234, 16'h4321);
        issue_request(FN_SPARE7, 6'd63, 6'd63, 16'shFFFF, 16'hFFFF);
        // strongly negative field: probability pinned at the top of the table
        issue_request(FN_BIAS, 6'd5, 6'd0, 16'sh8000, 16'd0);
        issue_request(FN_WEIGHT, 6'd5, 6'd6, 16'sh8000, 16'd0);
        issue_request(FN_WEIGHT, 6'd5, 6'd7, 16'sh8000, 16'd0);
        p = sb.site_chance(6'd5);
        issue_request(FN_ASYNC, 6'd5, 6'd0, 16'sd0, p - 16'd1);
        // strongly positive field: probability pinned at the bottom
        issue_request(FN_BIAS, 6'd9, 6'd0, 16'sh7FFF, 16'd0);
        issue_request(FN_WEIGHT, 6'd9, 6'd10, 16'sh7FFF, 16'd0);
        p = sb.site_chance(6'd9);
        issue_request(FN_ASYNC, 6'd9, 6'd0, 16'sd0, p);
        issue_request(FN_ASYNC, 6'd9, 6'd0, 16'sd0, 16'h0000);

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n % 100 == 0)
            begin
                steady_tx = ($urandom_range(0, 3) == 0);
                steady_rx = ($urandom_range(0, 3) == 0);
            end
            if (n == 250 || n == 500)
                settle_results();
            if (n == 260)
            begin
                // sink holds off while requests keep coming, so the block backs up
                steady_tx = 1'b1;
                rx_hold   = 300;
            end
            if ($urandom_range(0, 11) == 0)
                sync_sweep();
            else
                random_request();
        end

        settle_results();
        repeat (SITES + 8) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[boltzmann_gibbs_sampler] OK");
        else
            $display("[boltzmann_gibbs_sampler] ERROR");
        $finish;
    end

endmodule
